/* sv/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/bpc_pkg.sv */
// Types and constants for the barometer compensation block.
package bpc_pkg;

   localparam int CalW      = 16;
   localparam int RawW      = 24;
   localparam int TempW     = 15;
   localparam int PressW    = 17;
   localparam int CsrIdxW   = 3;
   localparam int NumStages = 9;

   // First-order temperature offset and low-temperature knee, 0.01 C.
   localparam int TempRef   = 2000;
   localparam int TempKnee  = 3500;   // TempRef - (-1500)

   localparam int TempMin   = -4000;
   localparam int TempMax   = 8500;
   localparam int PressMin  = 1000;
   localparam int PressMax  = 120000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PRESSURE_SENSITIVITY = 3'd0,
      CSR_PRESSURE_OFFSET      = 3'd1,
      CSR_SENS_TEMP_COEFF      = 3'd2,
      CSR_OFFSET_TEMP_COEFF    = 3'd3,
      CSR_REFERENCE_TEMP       = 3'd4,
      CSR_TEMP_COEFF           = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CalW-1:0] pressure_sensitivity;
      logic [CalW-1:0] pressure_offset;
      logic [CalW-1:0] sens_temp_coeff;
      logic [CalW-1:0] offset_temp_coeff;
      logic [CalW-1:0] reference_temp;
      logic [CalW-1:0] temp_coeff;
   } cal_type;

   typedef struct packed {
      logic [RawW-1:0] raw_pressure;
      logic [RawW-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [TempW-1:0] temperature;
      logic [PressW-1:0]       pressure;
      logic                    clamped;
   } rsp_type;

endpackage

/* sv/bpc_cal_regs.sv */
// Calibration register file, written through the CSR port.
module bpc_cal_regs
   import bpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CalW-1:0]    csr_wdata,
   output cal_type            cal
);

   cal_type cal_ff;
   cal_type cal_in;

   always_comb begin
      cal_in = cal_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PRESSURE_SENSITIVITY: cal_in.pressure_sensitivity = csr_wdata;
            CSR_PRESSURE_OFFSET:      cal_in.pressure_offset      = csr_wdata;
            CSR_SENS_TEMP_COEFF:      cal_in.sens_temp_coeff      = csr_wdata;
            CSR_OFFSET_TEMP_COEFF:    cal_in.offset_temp_coeff    = csr_wdata;
            CSR_REFERENCE_TEMP:       cal_in.reference_temp       = csr_wdata;
            CSR_TEMP_COEFF:           cal_in.temp_coeff           = csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

/* sv/baro_pressure_temp_compensation.sv */
// Top level: second-order pressure/temperature compensation pipeline.
//
//   port group | dir | transfer when          | carries
//   req_*      | in  | req_valid & !req_stall | raw_pressure, raw_temperature
//   rsp_*      | out | rsp_valid & !rsp_stall | temperature, pressure, clamped
//   csr_*      | in  | csr_we                 | calibration word write
//
// One sample pair per cycle sustained while the result is not stalled.
// The multiplier stages compute the dT products, the squares and the partial products of D1*SENS.
// Each stage holds only while the one after it is full and held, so bubbles close
// up behind a stalled result and input keeps flowing until the pipe is full.
// Synchronous reset empties the pipe and clears the calibration words to zero.
`include "assert_macros.svh"

module baro_pressure_temp_compensation
   import bpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CalW-1:0]    csr_wdata
);

   cal_type cal;

   bpc_cal_regs u_cal_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cal       (cal)
   );

   // ---------------- stage flow control ----------------
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic [NumStages:0]   stage_en;

   assign stage_en[NumStages] = ~rsp_stall;
   for (genvar k = 0; k < NumStages; k++) begin : g_en
      assign stage_en[k] = ~vld_ff[k] | stage_en[k+1];
   end

   assign vld_in = (stage_en[NumStages-1:0] & {vld_ff[NumStages-2:0], req_valid})
                 | (~stage_en[NumStages-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = ~stage_en[0];
   assign rsp_valid = vld_ff[NumStages-1];

   // ---------------- stage 0: dT ----------------
   logic [RawW-1:0]    s0_d1_ff, s0_d1_in;
   logic signed [24:0] s0_dt_ff, s0_dt_in;

   always_comb begin
      s0_d1_in = req_data.raw_pressure;
      s0_dt_in = $signed({1'b0, req_data.raw_temperature})
               - $signed({1'b0, cal.reference_temp, 8'b0});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_d1_ff <= s0_d1_in;
         s0_dt_ff <= s0_dt_in;
      end
   end

   // ---------------- stage 1: dT products ----------------
   logic [RawW-1:0]    s1_d1_ff, s1_d1_in;
   logic signed [40:0] s1_p6_ff, s1_p6_in;
   logic signed [40:0] s1_p4_ff, s1_p4_in;
   logic signed [40:0] s1_p3_ff, s1_p3_in;
   logic signed [48:0] s1_pdd_ff, s1_pdd_in;

   always_comb begin
      s1_d1_in  = s0_d1_ff;
      s1_p6_in  = s0_dt_ff * $signed({1'b0, cal.temp_coeff});
      s1_p4_in  = s0_dt_ff * $signed({1'b0, cal.offset_temp_coeff});
      s1_p3_in  = s0_dt_ff * $signed({1'b0, cal.sens_temp_coeff});
      s1_pdd_in = s0_dt_ff * s0_dt_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_d1_ff  <= s1_d1_in;
         s1_p6_ff  <= s1_p6_in;
         s1_p4_ff  <= s1_p4_in;
         s1_p3_ff  <= s1_p3_in;
         s1_pdd_ff <= s1_pdd_in;
      end
   end

   // ---------------- stage 2: TEMP, OFF, SENS ----------------
   logic signed [17:0] s2_a;      // TEMP - 2000
   logic signed [17:0] s2_a_neg;
   logic               s2_lt;     // below 20.00 C
   logic               s2_ltm;    // below -15.00 C
   logic [16:0]        s2_t2;
   logic signed [19:0] s2_t2x;

   logic [RawW-1:0]    s2_d1_ff, s2_d1_in;
   logic [16:0]        s2_amag_ff, s2_amag_in;
   logic [16:0]        s2_bmag_ff, s2_bmag_in;
   logic signed [19:0] s2_tcomp_ff, s2_tcomp_in;
   logic signed [34:0] s2_off_ff, s2_off_in;
   logic signed [33:0] s2_sens_ff, s2_sens_in;

   always_comb begin
      s2_a     = $signed(s1_p6_ff[40:23]);
      s2_a_neg = -s2_a;
      s2_lt    = s2_a[17];
      s2_ltm   = s2_a < -18'(TempKnee);
      s2_t2    = s1_pdd_ff[47:31];
      s2_t2x   = s2_lt ? $signed({3'b0, s2_t2}) : '0;

      s2_d1_in    = s1_d1_ff;
      s2_amag_in  = s2_lt ? s2_a_neg[16:0] : '0;
      s2_bmag_in  = s2_ltm ? 17'(s2_a_neg - 18'(TempKnee)) : '0;
      s2_tcomp_in = 20'(s2_a) + 20'(TempRef) - s2_t2x;
      s2_off_in   = $signed({3'b0, cal.pressure_offset, 16'b0})
                  + 35'($signed(s1_p4_ff[40:7]));
      s2_sens_in  = $signed({3'b0, cal.pressure_sensitivity, 15'b0})
                  + 34'($signed(s1_p3_ff[40:8]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_d1_ff    <= s2_d1_in;
         s2_amag_ff  <= s2_amag_in;
         s2_bmag_ff  <= s2_bmag_in;
         s2_tcomp_ff <= s2_tcomp_in;
         s2_off_ff   <= s2_off_in;
         s2_sens_ff  <= s2_sens_in;
      end
   end

   // ---------------- stage 3: squares ----------------
   logic [RawW-1:0]    s3_d1_ff, s3_d1_in;
   logic [33:0]        s3_aa_ff, s3_aa_in;
   logic [33:0]        s3_bb_ff, s3_bb_in;
   logic signed [19:0] s3_tcomp_ff, s3_tcomp_in;
   logic signed [34:0] s3_off_ff, s3_off_in;
   logic signed [33:0] s3_sens_ff, s3_sens_in;

   always_comb begin
      s3_d1_in    = s2_d1_ff;
      s3_aa_in    = s2_amag_ff * s2_amag_ff;
      s3_bb_in    = s2_bmag_ff * s2_bmag_ff;
      s3_tcomp_in = s2_tcomp_ff;
      s3_off_in   = s2_off_ff;
      s3_sens_in  = s2_sens_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_d1_ff    <= s3_d1_in;
         s3_aa_ff    <= s3_aa_in;
         s3_bb_ff    <= s3_bb_in;
         s3_tcomp_ff <= s3_tcomp_in;
         s3_off_ff   <= s3_off_in;
         s3_sens_ff  <= s3_sens_in;
      end
   end

   // ---------------- stage 4: OFF2, SENS2 ----------------
   logic [36:0] s4_five_aa;
   logic [36:0] s4_seven_bb;
   logic [37:0] s4_eleven_bb;

   logic [RawW-1:0]    s4_d1_ff, s4_d1_in;
   logic [37:0]        s4_off2_ff, s4_off2_in;
   logic [37:0]        s4_sens2_ff, s4_sens2_in;
   logic signed [19:0] s4_tcomp_ff, s4_tcomp_in;
   logic signed [34:0] s4_off_ff, s4_off_in;
   logic signed [33:0] s4_sens_ff, s4_sens_in;

   // Squares are zero when the correction does not apply, so no select here.
   always_comb begin
      s4_five_aa   = {s3_aa_ff, 2'b0} + 37'(s3_aa_ff);
      s4_seven_bb  = {s3_bb_ff, 3'b0} - 37'(s3_bb_ff);
      s4_eleven_bb = {1'b0, s3_bb_ff, 3'b0} + {3'b0, s3_bb_ff, 1'b0} + 38'(s3_bb_ff);

      s4_d1_in    = s3_d1_ff;
      s4_off2_in  = 38'(s4_five_aa[36:1]) + 38'(s4_seven_bb);
      s4_sens2_in = 38'(s4_five_aa[36:2]) + 38'(s4_eleven_bb[37:1]);
      s4_tcomp_in = s3_tcomp_ff;
      s4_off_in   = s3_off_ff;
      s4_sens_in  = s3_sens_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_d1_ff    <= s4_d1_in;
         s4_off2_ff  <= s4_off2_in;
         s4_sens2_ff <= s4_sens2_in;
         s4_tcomp_ff <= s4_tcomp_in;
         s4_off_ff   <= s4_off_in;
         s4_sens_ff  <= s4_sens_in;
      end
   end

   // ---------------- stage 5: corrected OFF and SENS ----------------
   logic [RawW-1:0]    s5_d1_ff, s5_d1_in;
   logic signed [39:0] s5_sens_ff, s5_sens_in;
   logic signed [39:0] s5_off_ff, s5_off_in;
   logic signed [19:0] s5_tcomp_ff, s5_tcomp_in;

   always_comb begin
      s5_d1_in    = s4_d1_ff;
      s5_sens_in  = 40'(s4_sens_ff) - $signed({2'b0, s4_sens2_ff});
      s5_off_in   = 40'(s4_off_ff) - $signed({2'b0, s4_off2_ff});
      s5_tcomp_in = s4_tcomp_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_d1_ff    <= s5_d1_in;
         s5_sens_ff  <= s5_sens_in;
         s5_off_ff   <= s5_off_in;
         s5_tcomp_ff <= s5_tcomp_in;
      end
   end

   // ---------------- stage 6: D1*SENS partial products ----------------
   logic [43:0]        s6_pl_ff, s6_pl_in;
   logic signed [44:0] s6_ph_ff, s6_ph_in;
   logic signed [39:0] s6_off_ff, s6_off_in;
   logic signed [19:0] s6_tcomp_ff, s6_tcomp_in;

   always_comb begin
      s6_pl_in    = s5_d1_ff * s5_sens_ff[19:0];
      s6_ph_in    = $signed({1'b0, s5_d1_ff}) * $signed(s5_sens_ff[39:20]);
      s6_off_in   = s5_off_ff;
      s6_tcomp_in = s5_tcomp_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_pl_ff    <= s6_pl_in;
         s6_ph_ff    <= s6_ph_in;
         s6_off_ff   <= s6_off_in;
         s6_tcomp_ff <= s6_tcomp_in;
      end
   end

   // ---------------- stage 7: combine partial products ----------------
   logic signed [64:0] s7_prod_ff, s7_prod_in;
   logic signed [39:0] s7_off_ff, s7_off_in;
   logic signed [19:0] s7_tcomp_ff, s7_tcomp_in;

   always_comb begin
      s7_prod_in  = $signed({s6_ph_ff, 20'b0}) + $signed({21'b0, s6_pl_ff});
      s7_off_in   = s6_off_ff;
      s7_tcomp_in = s6_tcomp_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_prod_ff  <= s7_prod_in;
         s7_off_ff   <= s7_off_in;
         s7_tcomp_ff <= s7_tcomp_in;
      end
   end

   // ---------------- stage 8: pressure, saturation, output ----------------
   logic signed [44:0] s8_q;
   logic signed [29:0] s8_p;
   logic               s8_t_lo, s8_t_hi, s8_p_lo, s8_p_hi;
   rsp_type            rsp_ff, rsp_in;

   always_comb begin
      s8_q    = 45'($signed(s7_prod_ff[64:21])) - 45'(s7_off_ff);
      s8_p    = $signed(s8_q[44:15]);
      s8_t_lo = s7_tcomp_ff < TempMin;
      s8_t_hi = s7_tcomp_ff > TempMax;
      s8_p_lo = s8_p < PressMin;
      s8_p_hi = s8_p > PressMax;

      if (s8_t_lo) begin
         rsp_in.temperature = TempW'(TempMin);
      end else if (s8_t_hi) begin
         rsp_in.temperature = TempW'(TempMax);
      end else begin
         rsp_in.temperature = s7_tcomp_ff[TempW-1:0];
      end

      if (s8_p_lo) begin
         rsp_in.pressure = PressW'(PressMin);
      end else if (s8_p_hi) begin
         rsp_in.pressure = PressW'(PressMax);
      end else begin
         rsp_in.pressure = s8_p[PressW-1:0];
      end

      rsp_in.clamped = s8_t_lo | s8_t_hi | s8_p_lo | s8_p_hi;
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------- checks ----------------
   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, &vld_ff, "input stalled with a bubble in the pipe")

   `ASSERT_NEXT(a_last_stage_moves, clock, reset, vld_ff[NumStages-2] && stage_en[NumStages-1], rsp_valid, "item lost at output stage")

   `ASSERT_IMPLY(a_clamp_at_bound, clock, reset, rsp_valid && rsp_data.pressure != PressW'(PressMin) && rsp_data.pressure != PressW'(PressMax) && rsp_data.temperature != TempW'(TempMin) && rsp_data.temperature != TempW'(TempMax), !rsp_data.clamped, "clamp flag set off the range bounds")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the barometer pressure/temperature compensation block.
module testbench;
   import bpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 19;
   localparam int SAMPLES_PER_SET = 100;
   localparam int QUIET_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 3 * NumStages;

   // Indexes with no register behind them; writes there must be dropped.
   localparam logic [CsrIdxW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_HI = 3'd7;

   // Typical calibration words from the sensor datasheet.
   localparam cal_type NOMINAL_CAL = {16'd40127, 16'd36924, 16'd23317,
                                      16'd23282, 16'd33464, 16'd28312};

   typedef enum logic {CAL_AT_RESET, CAL_NOMINAL} cal_set_type;

   typedef struct packed {
      cal_set_type cal_set;
      req_type     sample;
      logic        typed;
      rsp_type     result;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CalW-1:0]   csr_wdata = '0;

   cal_type          cal_shadow = '0;
   rsp_type          expected_readings[$];
   directed_row_type directed_rows[$];
   rsp_type          oldest_reading;

   int req_idle_pct  = 13;
   int rsp_stall_pct = 79;
   int fail_count       = 0;
   int readings_checked = 0;
   int readings_clamped = 0;
   int samples_sent     = 0;
   int cal_sets         = 0;

   baro_pressure_temp_compensation u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Second-order compensation, 64-bit exact; >>> floors like the datasheet shifts.
   function automatic rsp_type compensate(input req_type s);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, a, b, p, t_out, p_out;
      logic   hit;
      rsp_type r;
      d1 = {40'd0, s.raw_pressure};
      d2 = {40'd0, s.raw_temperature};
      c1 = {48'd0, cal_shadow.pressure_sensitivity};
      c2 = {48'd0, cal_shadow.pressure_offset};
      c3 = {48'd0, cal_shadow.sens_temp_coeff};
      c4 = {48'd0, cal_shadow.offset_temp_coeff};
      c5 = {48'd0, cal_shadow.reference_temp};
      c6 = {48'd0, cal_shadow.temp_coeff};
      hit   = 1'b0;
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      dt   = d2 - (c5 <<< 8);
      temp = 2000 + ((dt * c6) >>> 23);
      off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
      sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
      if (temp < 2000) begin
         a     = temp - 2000;
         t2    = (dt * dt) >>> 31;
         off2  = (5 * a * a) / 2;
         sens2 = (5 * a * a) / 4;
         if (temp < -1500) begin
            b     = temp + 1500;
            off2  = off2 + 7 * b * b;
            sens2 = sens2 + (11 * b * b) / 2;
         end
      end
      off  = off - off2;
      sens = sens - sens2;
      p = (((d1 * sens) >>> 21) - off) >>> 15;
      t_out = temp - t2;
      if (t_out < TempMin) begin
         t_out = TempMin;
         hit   = 1'b1;
      end else if (t_out > TempMax) begin
         t_out = TempMax;
         hit   = 1'b1;
      end
      p_out = p;
      if (p_out < PressMin) begin
         p_out = PressMin;
         hit   = 1'b1;
      end else if (p_out > PressMax) begin
         p_out = PressMax;
         hit   = 1'b1;
      end
      r.temperature = t_out[TempW-1:0];
      r.pressure    = p_out[PressW-1:0];
      r.clamped     = hit;
      return r;
   endfunction

   function automatic void add_row(input cal_set_type set, input logic [RawW-1:0] d1,
                                   input logic [RawW-1:0] d2, input logic typed,
                                   input int t, input int p, input logic cl);
      directed_row_type row;
      row.cal_set                = set;
      row.sample.raw_pressure    = d1;
      row.sample.raw_temperature = d2;
      row.typed                  = typed;
      row.result.temperature     = t[TempW-1:0];
      row.result.pressure        = p[PressW-1:0];
      row.result.clamped         = cl;
      directed_rows.push_back(row);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_sample(input req_type s, input rsp_type reading);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_readings.push_back(reading);
      samples_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding reading has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CalW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PRESSURE_SENSITIVITY: cal_shadow.pressure_sensitivity = value;
         CSR_PRESSURE_OFFSET:      cal_shadow.pressure_offset      = value;
         CSR_SENS_TEMP_COEFF:      cal_shadow.sens_temp_coeff      = value;
         CSR_OFFSET_TEMP_COEFF:    cal_shadow.offset_temp_coeff    = value;
         CSR_REFERENCE_TEMP:       cal_shadow.reference_temp       = value;
         CSR_TEMP_COEFF:           cal_shadow.temp_coeff           = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_cal(input cal_type c);
      write_reg(CSR_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
      write_reg(CSR_SPARE_LO, CalW'($urandom));
      write_reg(CSR_PRESSURE_OFFSET, c.pressure_offset);
      write_reg(CSR_SENS_TEMP_COEFF, c.sens_temp_coeff);
      write_reg(CSR_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
      write_reg(CSR_REFERENCE_TEMP, c.reference_temp);
      write_reg(CSR_TEMP_COEFF, c.temp_coeff);
      write_reg(CSR_SPARE_HI, CalW'($urandom));
      csr_we <= 1'b0;
      cal_sets++;
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("reading with no sample outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            oldest_reading = expected_readings.pop_front();
            readings_checked++;
            if (oldest_reading.clamped) readings_clamped++;
            if (rsp_data.temperature !== oldest_reading.temperature) begin
               $error("temperature: expected %0d, got %0d",
                      oldest_reading.temperature, rsp_data.temperature);
               fail_count++;
            end
            if (rsp_data.pressure !== oldest_reading.pressure) begin
               $error("pressure: expected %0d, got %0d",
                      oldest_reading.pressure, rsp_data.pressure);
               fail_count++;
            end
            if (rsp_data.clamped !== oldest_reading.clamped) begin
               $error("clamped: expected %0b, got %0b",
                      oldest_reading.clamped, rsp_data.clamped);
               fail_count++;
            end
         end
      end
   end

   // Ends the run if no transfer happens on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      cal_type     next_cal;
      cal_set_type active_set;
      req_type     s;
      int          d2_val;
      int          phase;

      // Zero calibration: dT is D2, TEMP sits at 20.00 C, SENS and OFF are zero.
      add_row(CAL_AT_RESET, 24'h000000, 24'h000000, 1'b1, 2000, 1000, 1'b1);
      add_row(CAL_AT_RESET, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 2000, 1000, 1'b1);
      add_row(CAL_AT_RESET, 24'hFFFFFF, 24'h000000, 1'b1, 2000, 1000, 1'b1);
      add_row(CAL_AT_RESET, 24'h000000, 24'hFFFFFF, 1'b1, 2000, 1000, 1'b1);
      add_row(CAL_AT_RESET, 24'hAAAAAA, 24'h555555, 1'b1, 2000, 1000, 1'b1);
      // Nominal calibration: datasheet example, clamps, knees at 20 C and -15 C.
      add_row(CAL_NOMINAL, 24'd9085466, 24'd8569150, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd0, 24'd8569150, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'hFFFFFF, 24'd8569150, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd0, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'hFFFFFF, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd8566784, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd8566783, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd8400000, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd8000000, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd7800000, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd7500000, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd9085466, 24'd7000000, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd4000000, 24'd8569150, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'd12000000, 24'd8569150, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'hAAAAAA, 24'h555555, 1'b0, 0, 0, 1'b0);
      add_row(CAL_NOMINAL, 24'h555555, 24'hAAAAAA, 1'b0, 0, 0, 1'b0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      active_set = CAL_AT_RESET;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cal_set != active_set) begin
            settle();
            program_cal(NOMINAL_CAL);
            active_set = directed_rows[i].cal_set;
         end
         send_sample(directed_rows[i].sample,
                     directed_rows[i].typed ? directed_rows[i].result
                                            : compensate(directed_rows[i].sample));
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < 6) begin
            req_idle_pct  = 13;
            rsp_stall_pct = 79;
         end else if (phase < 12) begin
            req_idle_pct  = 79;
            rsp_stall_pct = 13;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         case (phase % 5)
            0, 2: begin
               // jitter around the nominal words keeps results mostly in range
               next_cal.pressure_sensitivity = CalW'(NOMINAL_CAL.pressure_sensitivity
                                               + $urandom_range(0, 4000) - 2000);
               next_cal.pressure_offset      = CalW'(NOMINAL_CAL.pressure_offset
                                               + $urandom_range(0, 4000) - 2000);
               next_cal.sens_temp_coeff      = CalW'(NOMINAL_CAL.sens_temp_coeff
                                               + $urandom_range(0, 4000) - 2000);
               next_cal.offset_temp_coeff    = CalW'(NOMINAL_CAL.offset_temp_coeff
                                               + $urandom_range(0, 4000) - 2000);
               next_cal.reference_temp       = CalW'(NOMINAL_CAL.reference_temp
                                               + $urandom_range(0, 4000) - 2000);
               next_cal.temp_coeff           = CalW'(NOMINAL_CAL.temp_coeff
                                               + $urandom_range(0, 4000) - 2000);
            end
            3: next_cal = ((phase / 5) % 2 == 0) ? '1 : '0;
            default: next_cal = {$urandom, $urandom, $urandom};
         endcase
         settle();
         program_cal(next_cal);
         repeat (SAMPLES_PER_SET) begin
            if ($urandom_range(0, 2) == 0)
               s.raw_pressure = RawW'($urandom);
            else
               s.raw_pressure = RawW'($urandom_range(4000000, 14000000));
            if ($urandom_range(0, 3) == 0) begin
               s.raw_temperature = RawW'($urandom);
            end else begin
               // land near the reference so dT stays where TEMP is meaningful
               d2_val = int'(cal_shadow.reference_temp) * 256
                        + int'($urandom_range(0, 3 << 20)) - (2 << 20);
               if (d2_val < 0) d2_val = 0;
               if (d2_val > 16777215) d2_val = 16777215;
               s.raw_temperature = d2_val[RawW-1:0];
            end
            send_sample(s, compensate(s));
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0) begin
         $error("%0d readings never arrived", expected_readings.size());
         fail_count++;
      end
      $display("Sent %0d sample pairs over %0d calibration sets; %0d readings checked.",
               samples_sent, cal_sets, readings_checked);
      $display("%0d readings were saturated to the sensor range.", readings_clamped);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
